FILE: rtl/text_console_cursor_scroll_unit_assert.svh
// assertion macros for the text console rtl
// no dependencies; the checking forms compile away when SYNTHESIS is set
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold on every clock edge out of reset
`define CTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("console check failed");
// condition in one cycle implies a consequence in the next
`define CTS_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("console sequencing check failed");
`else
`define CTS_ASSERT(lbl, clk, rst_n, prop)
`define CTS_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq)
`endif
`endif

FILE: rtl/cts_pkg.sv
// shared types and constants for the text console cursor and scroll unit
// no dependencies
package cts_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam int REQ_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int READ_ROW_W   = 5;
    localparam int READ_COL_W   = 7;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int CELL_W       = CHAR_W + ATTR_W;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCROLL,
        ST_FILL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [CURSOR_COL_W-1:0] cursor_col;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CHAR_W-1:0]       cell_char;
        logic [ATTR_W-1:0]       cell_attr;
        logic                    scrolled;
    } res_t;

endpackage

FILE: rtl/cts_cell_mem.sv
// cell store: one write port, one read port with registered read data
// depends on cts_pkg for the cell width
module cts_cell_mem #(
    parameter int DEPTH  = cts_pkg::COLS_DEF * cts_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [cts_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [cts_pkg::CELL_W-1:0]  rd_data
);

    logic [cts_pkg::CELL_W-1:0] mem [DEPTH];
    logic [cts_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/cts_seq.sv
// request sequencer: cursor state, shared sweep counter for clear/scroll/init
// depends on cts_pkg, the assertion header and drives cts_cell_mem ports
`include "text_console_cursor_scroll_unit_assert.svh"

module cts_seq #(
    parameter int COLS   = cts_pkg::COLS_DEF,
    parameter int ROWS   = cts_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(COLS * ROWS)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cts_pkg::REQ_W-1:0]         s_req_type,
    input  logic [cts_pkg::CHAR_W-1:0]        s_char_code,
    input  logic [cts_pkg::ATTR_W-1:0]        s_attr,
    input  logic [cts_pkg::READ_ROW_W-1:0]    s_read_row,
    input  logic [cts_pkg::READ_COL_W-1:0]    s_read_col,
    input  logic                              slot_free,
    output logic                              res_valid,
    output cts_pkg::res_t                     res,
    output logic                              wr_en,
    output logic [ADDR_W-1:0]                 wr_addr,
    output logic [cts_pkg::CELL_W-1:0]        wr_data,
    output logic                              rd_en,
    output logic [ADDR_W-1:0]                 rd_addr,
    input  logic [cts_pkg::CELL_W-1:0]        rd_data
);

    localparam int CELLS = COLS * ROWS;
    localparam int COL_W = $clog2(COLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int CCW   = cts_pkg::CURSOR_COL_W;
    localparam int CRW   = cts_pkg::CURSOR_ROW_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

    cts_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]                sw_reg, sw_next;
    logic                             cp_vld_reg, cp_vld_next;
    logic [ADDR_W-1:0]                cp_addr_reg, cp_addr_next;
    logic [COL_W-1:0]                 col_reg, col_next;
    logic [ROW_W-1:0]                 row_reg, row_next;
    logic [cts_pkg::REQ_W-1:0]        req_reg, req_next;
    logic [cts_pkg::CHAR_W-1:0]       ch_reg, ch_next;
    logic [cts_pkg::ATTR_W-1:0]       attr_reg, attr_next;
    logic [cts_pkg::READ_ROW_W-1:0]   rr_reg, rr_next;
    logic [cts_pkg::READ_COL_W-1:0]   rc_reg, rc_next;
    logic [cts_pkg::CHAR_W-1:0]       rdc_reg, rdc_next;
    logic [cts_pkg::ATTR_W-1:0]       rda_reg, rda_next;
    logic                             scr_reg, scr_next;

    logic                             in_fire;
    logic [ADDR_W-1:0]                row_base;
    logic [ADDR_W-1:0]                rd_cell_addr;
    logic                             rd_in_range;
    logic [COL_W-1:0]                 col_m1;

    // row base shared by put and backspace writes
    assign row_base     = ADDR_W'(ADDR_W'(row_reg) * COLS_A);
    assign rd_cell_addr = ADDR_W'(ADDR_W'(rr_reg) * COLS_A) + ADDR_W'(rc_reg);
    assign rd_in_range  = (int'(rr_reg) < ROWS) && (int'(rc_reg) < COLS);
    assign col_m1       = col_reg - COL_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cts_pkg::ST_INIT;
            sw_reg     <= '0;
            cp_vld_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            sw_reg     <= sw_next;
            cp_vld_reg <= cp_vld_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg <= cp_addr_next;
        req_reg     <= req_next;
        ch_reg      <= ch_next;
        attr_reg    <= attr_next;
        rr_reg      <= rr_next;
        rc_reg      <= rc_next;
        rdc_reg     <= rdc_next;
        rda_reg     <= rda_next;
        scr_reg     <= scr_next;
    end

    always_comb begin
        state_next   = state_reg;
        sw_next      = sw_reg;
        cp_vld_next  = 1'b0;
        cp_addr_next = cp_addr_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        req_next     = req_reg;
        ch_next      = ch_reg;
        attr_next    = attr_reg;
        rr_next      = rr_reg;
        rc_next      = rc_reg;
        rdc_next     = rdc_reg;
        rda_next     = rda_reg;
        scr_next     = scr_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        s_ready      = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            cts_pkg::ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = sw_reg;
                wr_data = {cts_pkg::RESET_ATTR, cts_pkg::CH_SPACE};
                if (sw_reg == LAST_ADDR) begin
                    sw_next    = '0;
                    state_next = cts_pkg::ST_IDLE;
                end else begin
                    sw_next = sw_reg + ADDR_W'(1);
                end
            end
            cts_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            cts_pkg::ST_EXEC: begin
                rdc_next   = '0;
                rda_next   = '0;
                scr_next   = 1'b0;
                state_next = cts_pkg::ST_RESP;
                case (req_reg)
                    cts_pkg::REQ_PUT: begin
                        if (ch_reg == cts_pkg::CH_NEWLINE) begin
                            col_next = '0;
                            if (row_reg == ROW_LAST) begin
                                scr_next   = 1'b1;
                                sw_next    = '0;
                                state_next = cts_pkg::ST_SCROLL;
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end else if (ch_reg == cts_pkg::CH_BACKSPACE) begin
                            // never crosses into the previous row
                            if (col_reg != '0) begin
                                col_next = col_m1;
                                wr_en    = 1'b1;
                                wr_addr  = row_base + ADDR_W'(col_m1);
                                wr_data  = {attr_reg, cts_pkg::CH_SPACE};
                            end
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = row_base + ADDR_W'(col_reg);
                            wr_data = {attr_reg, ch_reg};
                            if (col_reg == COL_LAST) begin
                                col_next = '0;
                                if (row_reg == ROW_LAST) begin
                                    scr_next   = 1'b1;
                                    sw_next    = '0;
                                    state_next = cts_pkg::ST_SCROLL;
                                end else begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    end
                    cts_pkg::REQ_CLEAR: begin
                        col_next   = '0;
                        row_next   = '0;
                        sw_next    = '0;
                        state_next = cts_pkg::ST_FILL;
                    end
                    cts_pkg::REQ_READ: begin
                        if (rd_in_range) begin
                            rd_en      = 1'b1;
                            rd_addr    = rd_cell_addr;
                            state_next = cts_pkg::ST_RDWAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            cts_pkg::ST_RDWAIT: begin
                rdc_next   = rd_data[cts_pkg::CHAR_W-1:0];
                rda_next   = rd_data[cts_pkg::CELL_W-1:cts_pkg::CHAR_W];
                state_next = cts_pkg::ST_RESP;
            end
            cts_pkg::ST_SCROLL: begin
                // read one row ahead, write the returned cell in the next cycle
                if (cp_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = cp_addr_reg;
                    wr_data = rd_data;
                end
                if (sw_reg != COPY_END) begin
                    rd_en        = 1'b1;
                    rd_addr      = sw_reg + COLS_A;
                    cp_vld_next  = 1'b1;
                    cp_addr_next = sw_reg;
                    sw_next      = sw_reg + ADDR_W'(1);
                end else begin
                    state_next = cts_pkg::ST_FILL;
                end
            end
            cts_pkg::ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = sw_reg;
                wr_data = {attr_reg, cts_pkg::CH_SPACE};
                if (sw_reg == LAST_ADDR) begin
                    sw_next    = '0;
                    state_next = cts_pkg::ST_RESP;
                end else begin
                    sw_next = sw_reg + ADDR_W'(1);
                end
            end
            cts_pkg::ST_RESP: begin
                res_valid = 1'b1;
                s_ready   = slot_free;
                if (slot_free) begin
                    state_next = cts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cts_pkg::ST_IDLE;
            end
        endcase

        in_fire = s_valid && s_ready;
        if (in_fire) begin
            req_next   = s_req_type;
            ch_next    = s_char_code;
            attr_next  = s_attr;
            rr_next    = s_read_row;
            rc_next    = s_read_col;
            state_next = cts_pkg::ST_EXEC;
        end
    end

    always_comb begin
        res.cursor_col = CCW'(col_reg);
        res.cursor_row = CRW'(row_reg);
        res.cell_char  = rdc_reg;
        res.cell_attr  = rda_reg;
        res.scrolled   = scr_reg;
    end

    `CTS_ASSERT(a_cursor_in_screen, aclk, aresetn, (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
    `CTS_ASSERT(a_write_in_store, aclk, aresetn, !wr_en || (wr_addr <= LAST_ADDR))
    `CTS_ASSERT_NEXT(a_transfer_starts_exec, aclk, aresetn, in_fire, state_reg == cts_pkg::ST_EXEC)
    `CTS_ASSERT_NEXT(a_copy_then_fill, aclk, aresetn, (state_reg == cts_pkg::ST_SCROLL) && (sw_reg == COPY_END), state_reg == cts_pkg::ST_FILL)

endmodule

FILE: rtl/text_console_cursor_scroll_unit.sv
// Character-cell text console, ROWS x COLS cells of character and attribute.
// Input channel s_*: one request per transfer (put character, clear, read cell).
// Result channel m_*: exactly one result per request, in request order: the
// cursor after the request, the cell read (zero unless a read hit the screen)
// and a flag set when the request scrolled the screen.
// A put without scroll, an unused code or an out-of-screen read goes from
// execute straight to the result; a read waits for the registered store data;
// a clear blanks all cells; a scrolling put copies rows up, then blanks the
// last row. A request waits for the last one's result. The cell store's
// single write port, walked by one sweep counter, sets clear and scroll times.
// The next request is accepted while a finished result waits in the output
// register, and if m_ready stays low the block holds once that request is done.
// After aresetn the store is blanked to spaces with attribute 0x0F in one pass
// over all ROWS*COLS cells; s_ready stays low meanwhile.
// Depends on cts_pkg, cts_seq and cts_cell_mem.
module text_console_cursor_scroll_unit #(
    parameter int COLS = cts_pkg::COLS_DEF,
    parameter int ROWS = cts_pkg::ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cts_pkg::REQ_W-1:0]         s_req_type,
    input  logic [cts_pkg::CHAR_W-1:0]        s_char_code,
    input  logic [cts_pkg::ATTR_W-1:0]        s_attr,
    input  logic [cts_pkg::READ_ROW_W-1:0]    s_read_row,
    input  logic [cts_pkg::READ_COL_W-1:0]    s_read_col,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cts_pkg::CURSOR_COL_W-1:0]  m_cursor_col,
    output logic [cts_pkg::CURSOR_ROW_W-1:0]  m_cursor_row,
    output logic [cts_pkg::CHAR_W-1:0]        m_cell_char,
    output logic [cts_pkg::ATTR_W-1:0]        m_cell_attr,
    output logic                              m_scrolled
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic                        slot_free;
    logic                        res_valid;
    cts_pkg::res_t               res;
    cts_pkg::res_t               out_reg;
    logic                        m_valid_reg;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [cts_pkg::CELL_W-1:0]  wr_data;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [cts_pkg::CELL_W-1:0]  rd_data;

    assign slot_free = !m_valid_reg || m_ready;

    cts_seq #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_char_code (s_char_code),
        .s_attr      (s_attr),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .slot_free   (slot_free),
        .res_valid   (res_valid),
        .res         (res),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    cts_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register decouples the result side from the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (slot_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_col = out_reg.cursor_col;
    assign m_cursor_row = out_reg.cursor_row;
    assign m_cell_char  = out_reg.cell_char;
    assign m_cell_attr  = out_reg.cell_attr;
    assign m_scrolled   = out_reg.scrolled;

endmodule
